/* rtl/flr_pkg.sv */
package flr_pkg;

   localparam int unsigned CH_W = 8;

   typedef logic [CH_W-1:0] char_type;

   typedef enum logic [3:0] {
      ST_START = 4'd0,
      ST_INT   = 4'd1,
      ST_POINT = 4'd2,
      ST_MANT  = 4'd3,
      ST_EXP   = 4'd4,
      ST_SIGN  = 4'd5,
      ST_EXPD  = 4'd6,
      ST_SUF   = 4'd7,
      ST_DEAD  = 4'd8
   } scan_state_type;

   localparam char_type CHR_0     = 8'h30;
   localparam char_type CHR_9     = 8'h39;
   localparam char_type CHR_POINT = 8'h2e;
   localparam char_type CHR_PLUS  = 8'h2b;
   localparam char_type CHR_MINUS = 8'h2d;
   localparam char_type CHR_LO_E  = 8'h65;
   localparam char_type CHR_UP_E  = 8'h45;
   localparam char_type CHR_LO_F  = 8'h66;
   localparam char_type CHR_UP_F  = 8'h46;
   localparam char_type CHR_LO_L  = 8'h6c;
   localparam char_type CHR_UP_L  = 8'h4c;

   typedef struct packed {
      logic is_digit;
      logic is_point;
      logic is_exp;
      logic is_sign;
      logic is_suffix;
   } char_class_type;

endpackage

/* rtl/flr_intf.sv */
interface flr_req_if;
   logic               valid;
   logic               ready;
   flr_pkg::char_type  ch;
   logic               last;

   modport source (output valid, output ch, output last, input ready);
   modport sink (input valid, input ch, input last, output ready);
endinterface

interface flr_rsp_if;
   logic valid;
   logic ready;
   logic is_float;

   modport source (output valid, output is_float, input ready);
   modport sink (input valid, input is_float, output ready);
endinterface

/* rtl/float_literal_recognizer_core.sv */
// Recognizes C decimal floating constants. A token arrives one byte per transaction on req,
// with last set on its final byte; after that byte one transaction on rsp carries is_float,
// and bytes that are not last produce nothing. One byte is taken every cycle while rsp keeps
// up: each byte is held in the input register, where a single state transition of the
// scanner decides the next scanner state; for a last byte the verdict is written from there
// to the result register, which drives is_float on rsp. A result waiting on rsp holds back
// only a following last byte; other bytes keep flowing.
module float_literal_recognizer_core (
   input logic     clock,
   input logic     reset,
   flr_req_if.sink req,
   flr_rsp_if.source rsp
);

   logic                    in_valid_ff, in_valid_in;
   flr_pkg::char_type       in_ch_ff, in_ch_in;
   logic                    in_last_ff, in_last_in;

   flr_pkg::scan_state_type scan_state_ff, scan_state_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    out_float_ff, out_float_in;

   flr_pkg::scan_state_type state_next;
   logic                    accepting;
   logic                    out_free;
   logic                    stage_move;
   logic                    take;

   flr_scan_step u_step (
      .state      (scan_state_ff),
      .ch         (in_ch_ff),
      .state_next (state_next),
      .accepting  (accepting)
   );

   // a last byte needs the result register free, other bytes only update the state
   assign out_free   = !out_valid_ff || rsp.ready;
   assign stage_move = in_valid_ff && (!in_last_ff || out_free);
   assign req.ready  = !in_valid_ff || stage_move;
   assign take       = req.valid && req.ready;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_ch_in      = in_ch_ff;
      in_last_in    = in_last_ff;
      scan_state_in = scan_state_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_float_in  = out_float_ff;

      if (stage_move) begin
         in_valid_in = 1'b0;
         if (in_last_ff) begin
            scan_state_in = flr_pkg::ST_START;
            out_valid_in  = 1'b1;
            out_float_in  = accepting;
         end else begin
            scan_state_in = state_next;
         end
      end

      if (take) begin
         in_valid_in = 1'b1;
         in_ch_in    = req.ch;
         in_last_in  = req.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         scan_state_ff <= flr_pkg::ST_START;
         out_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         scan_state_ff <= scan_state_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ch_ff     <= in_ch_in;
      in_last_ff   <= in_last_in;
      out_float_ff <= out_float_in;
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.is_float = out_float_ff;

endmodule

/* rtl/flr_scan_step.sv */
module flr_scan_step (
   input  flr_pkg::scan_state_type state,
   input  flr_pkg::char_type       ch,
   output flr_pkg::scan_state_type state_next,
   output logic                    accepting
);

   flr_pkg::char_class_type cls;

   always_comb begin
      cls.is_digit  = (ch >= flr_pkg::CHR_0) && (ch <= flr_pkg::CHR_9);
      cls.is_point  = (ch == flr_pkg::CHR_POINT);
      cls.is_exp    = (ch == flr_pkg::CHR_LO_E) || (ch == flr_pkg::CHR_UP_E);
      cls.is_sign   = (ch == flr_pkg::CHR_PLUS) || (ch == flr_pkg::CHR_MINUS);
      cls.is_suffix = (ch == flr_pkg::CHR_LO_F) || (ch == flr_pkg::CHR_UP_F) ||
                      (ch == flr_pkg::CHR_LO_L) || (ch == flr_pkg::CHR_UP_L);
   end

   always_comb begin
      state_next = flr_pkg::ST_DEAD;
      unique case (state)
         flr_pkg::ST_START: begin
            if (cls.is_digit) state_next = flr_pkg::ST_INT;
            else if (cls.is_point) state_next = flr_pkg::ST_POINT;
         end
         flr_pkg::ST_INT: begin
            if (cls.is_digit) state_next = flr_pkg::ST_INT;
            else if (cls.is_point) state_next = flr_pkg::ST_MANT;
            else if (cls.is_exp) state_next = flr_pkg::ST_EXP;
         end
         flr_pkg::ST_POINT: begin
            if (cls.is_digit) state_next = flr_pkg::ST_MANT;
         end
         flr_pkg::ST_MANT: begin
            if (cls.is_digit) state_next = flr_pkg::ST_MANT;
            else if (cls.is_exp) state_next = flr_pkg::ST_EXP;
            else if (cls.is_suffix) state_next = flr_pkg::ST_SUF;
         end
         flr_pkg::ST_EXP: begin
            if (cls.is_sign) state_next = flr_pkg::ST_SIGN;
            else if (cls.is_digit) state_next = flr_pkg::ST_EXPD;
         end
         flr_pkg::ST_SIGN: begin
            if (cls.is_digit) state_next = flr_pkg::ST_EXPD;
         end
         flr_pkg::ST_EXPD: begin
            if (cls.is_digit) state_next = flr_pkg::ST_EXPD;
            else if (cls.is_suffix) state_next = flr_pkg::ST_SUF;
         end
         default: begin
            state_next = flr_pkg::ST_DEAD;
         end
      endcase
   end

   assign accepting = (state_next == flr_pkg::ST_MANT) ||
                      (state_next == flr_pkg::ST_EXPD) ||
                      (state_next == flr_pkg::ST_SUF);

endmodule

/* dv/float_literal_recognizer_core_tb.sv */
`timescale 1ns / 1ps

module float_literal_recognizer_core_tb;
   import flr_pkg::*;

   localparam int NO_TAIL     = -1;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_BYTES = 120;

   typedef struct {
      string text;
      int    tail;
      bit    typed;
      logic  verdict;
   } token_row_type;

   logic clock;
   logic reset;

   flr_req_if req_if ();
   flr_rsp_if rsp_if ();

   float_literal_recognizer_core i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // typed verdicts only where the answer is obvious, the rest come from next_scan
   token_row_type directed_rows [24] = '{
      '{"1.5",     NO_TAIL, 1'b1, 1'b1},
      '{"",        8'h00,   1'b1, 1'b0},
      '{"",        8'hff,   1'b1, 1'b0},
      '{"1.5",     8'hff,   1'b1, 1'b0},
      '{"1.5",     8'h00,   1'b1, 1'b0},
      '{"1e",      NO_TAIL, 1'b1, 1'b0},
      '{"123",     NO_TAIL, 1'b0, 1'b0},
      '{"123f",    NO_TAIL, 1'b0, 1'b0},
      '{".5",      NO_TAIL, 1'b0, 1'b0},
      '{"5.",      NO_TAIL, 1'b0, 1'b0},
      '{".",       NO_TAIL, 1'b0, 1'b0},
      '{"1e10",    NO_TAIL, 1'b0, 1'b0},
      '{"1.5e+3",  NO_TAIL, 1'b0, 1'b0},
      '{"1.5E-3L", NO_TAIL, 1'b0, 1'b0},
      '{"1.e5f",   NO_TAIL, 1'b0, 1'b0},
      '{"1e+5F",   NO_TAIL, 1'b0, 1'b0},
      '{"0x1p3",   NO_TAIL, 1'b0, 1'b0},
      '{"1.5ff",   NO_TAIL, 1'b0, 1'b0},
      '{"1.5x7",   NO_TAIL, 1'b0, 1'b0},
      '{"e5",      NO_TAIL, 1'b0, 1'b0},
      '{"1.5e+",   NO_TAIL, 1'b0, 1'b0},
      '{"9.9e-9l", NO_TAIL, 1'b0, 1'b0},
      '{".e1",     NO_TAIL, 1'b0, 1'b0},
      '{"00.00",   NO_TAIL, 1'b0, 1'b0}
   };

   scan_state_type scan_st;
   logic           verdict_q [$];
   char_type       token_buf [$];
   logic           want;

   int send_idle_pct;
   int take_idle_pct;
   int errors;
   int bytes_sent;
   int tokens_sent;
   int floats_seen;
   int verdicts_checked;
   int stall_cycles;

   always #1 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
   endtask

   function automatic scan_state_type next_scan(scan_state_type s, char_type c);
      logic dig, pnt, ex, sgn, sfx;
      scan_state_type nxt;
      dig = (c >= CHR_0) && (c <= CHR_9);
      pnt = (c == CHR_POINT);
      ex  = (c == CHR_LO_E) || (c == CHR_UP_E);
      sgn = (c == CHR_PLUS) || (c == CHR_MINUS);
      sfx = (c == CHR_LO_F) || (c == CHR_UP_F) || (c == CHR_LO_L) || (c == CHR_UP_L);
      nxt = ST_DEAD;
      case (s)
         ST_START: begin
            if (dig) nxt = ST_INT;
            else if (pnt) nxt = ST_POINT;
         end
         ST_INT: begin
            if (dig) nxt = ST_INT;
            else if (pnt) nxt = ST_MANT;
            else if (ex) nxt = ST_EXP;
         end
         ST_POINT: begin
            if (dig) nxt = ST_MANT;
         end
         ST_MANT: begin
            if (dig) nxt = ST_MANT;
            else if (ex) nxt = ST_EXP;
            else if (sfx) nxt = ST_SUF;
         end
         ST_EXP: begin
            if (sgn) nxt = ST_SIGN;
            else if (dig) nxt = ST_EXPD;
         end
         ST_SIGN: begin
            if (dig) nxt = ST_EXPD;
         end
         ST_EXPD: begin
            if (dig) nxt = ST_EXPD;
            else if (sfx) nxt = ST_SUF;
         end
         default: nxt = ST_DEAD;
      endcase
      return nxt;
   endfunction

   // advances the scanner on one byte, returns the verdict when the token closes
   function automatic logic step_scanner(char_type c, logic fin);
      scan_state_type nxt;
      nxt = next_scan(scan_st, c);
      scan_st = fin ? ST_START : nxt;
      return fin && (nxt inside {ST_MANT, ST_EXPD, ST_SUF});
   endfunction

   function automatic char_type any_digit();
      return CHR_0 + char_type'($urandom_range(9));
   endfunction

   function automatic char_type any_suffix();
      case ($urandom_range(3))
         0: return CHR_LO_F;
         1: return CHR_UP_F;
         2: return CHR_LO_L;
         default: return CHR_UP_L;
      endcase
   endfunction

   function automatic char_type lexeme_char();
      case ($urandom_range(5))
         0: return any_digit();
         1: return CHR_POINT;
         2: return $urandom_range(1) ? CHR_LO_E : CHR_UP_E;
         3: return $urandom_range(1) ? CHR_PLUS : CHR_MINUS;
         4: return any_suffix();
         default: return char_type'($urandom_range(255));
      endcase
   endfunction

   function automatic void add_digits(int lo, int hi);
      int n;
      n = $urandom_range(hi, lo);
      repeat (n) token_buf.push_back(any_digit());
   endfunction

   function automatic void build_float();
      int form;
      form = $urandom_range(2);
      token_buf.delete();
      case (form)
         0: add_digits(1, 4);
         1: begin
            add_digits(0, 3);
            token_buf.push_back(CHR_POINT);
            add_digits(1, 4);
         end
         default: begin
            add_digits(1, 4);
            token_buf.push_back(CHR_POINT);
            add_digits(0, 3);
         end
      endcase
      // exponent is mandatory without a point
      if (form == 0 || $urandom_range(1)) begin
         token_buf.push_back($urandom_range(1) ? CHR_LO_E : CHR_UP_E);
         if ($urandom_range(1)) token_buf.push_back($urandom_range(1) ? CHR_PLUS : CHR_MINUS);
         add_digits(1, 3);
      end
      if ($urandom_range(2) == 0) token_buf.push_back(any_suffix());
   endfunction

   function automatic void build_random_token();
      int pick, pos, n;
      pick = $urandom_range(99);
      if (pick < 70) begin
         build_float();
      end else if (pick < 80) begin
         token_buf.delete();
         add_digits(1, 5);
         if ($urandom_range(1)) token_buf.push_back(any_suffix());
      end else if (pick < 92) begin
         // well-formed token with one defect
         build_float();
         pos = $urandom_range(token_buf.size() - 1);
         case ($urandom_range(2))
            0: token_buf[pos] = lexeme_char();
            1: token_buf.insert(pos, lexeme_char());
            default: if (token_buf.size() > 1) void'(token_buf.pop_back());
         endcase
      end else begin
         token_buf.delete();
         n = $urandom_range(6, 1);
         repeat (n) token_buf.push_back(char_type'($urandom_range(255)));
      end
   endfunction

   task automatic send_char(input char_type c, input logic fin, output logic verdict);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.ch    <= c;
      req_if.last  <= fin;
      do @(posedge clock); while (!req_if.ready);
      verdict = step_scanner(c, fin);
      bytes_sent++;
   endtask

   task automatic send_token(input bit typed, input logic typed_verdict);
      int i;
      logic v;
      for (i = 0; i < token_buf.size(); i++) begin
         send_char(token_buf[i], i == token_buf.size() - 1, v);
      end
      verdict_q.push_back(typed ? typed_verdict : v);
      tokens_sent++;
      if (v) floats_seen++;
   endtask

   task automatic drain_verdicts();
      req_if.valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= take_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (verdict_q.size() == 0) begin
            report_mismatch($sformatf("is_float %0b with no token pending", rsp_if.is_float));
         end else begin
            want = verdict_q.pop_front();
            verdicts_checked++;
            if (rsp_if.is_float !== want) begin
               report_mismatch($sformatf("is_float %0b, expected %0b", rsp_if.is_float, want));
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles, %0d verdicts outstanding",
                     STALL_LIMIT, verdict_q.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int phase;
      int phase_start;
      clock         = 1'b0;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.ch     = '0;
      req_if.last   = 1'b0;
      rsp_if.ready  = 1'b0;
      send_idle_pct = 0;
      take_idle_pct = 0;
      scan_st       = ST_START;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         token_buf.delete();
         for (int i = 0; i < directed_rows[r].text.len(); i++) begin
            token_buf.push_back(char_type'(directed_rows[r].text[i]));
         end
         if (directed_rows[r].tail != NO_TAIL) token_buf.push_back(char_type'(directed_rows[r].tail));
         send_token(directed_rows[r].typed, directed_rows[r].verdict);
      end
      drain_verdicts();

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 15;
               take_idle_pct = 72;
            end
            1: begin
               send_idle_pct = 72;
               take_idle_pct = 15;
            end
            default: begin
               send_idle_pct = 0;
               take_idle_pct = 0;
            end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            build_random_token();
            send_token(1'b0, 1'b0);
         end
         // hold off until the scanner has answered everything
         drain_verdicts();
      end

      repeat (8) @(posedge clock);
      $display("scanned %0d tokens in %0d bytes, %0d floating constants, %0d verdicts checked",
               tokens_sent, bytes_sent, floats_seen, verdicts_checked);
      $display("idle mix: sender 15%% / receiver 72%%, then swapped, then back-to-back");
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* float_literal_recognizer_core.f */
rtl/flr_pkg.sv
rtl/flr_intf.sv
rtl/flr_scan_step.sv
rtl/float_literal_recognizer_core.sv
dv/float_literal_recognizer_core_tb.sv
